@@ rtl/core/wrt_pkg.sv @@
// Shared types, result codes and default sizes of the window reassembly tracker.
// Depends on nothing; every other file imports it.
package wrt_pkg;

    // default sizes of the receive window
    localparam int DEF_WINDOW_BYTES  = 4096;
    localparam int DEF_CHUNK_BYTES   = 512;
    localparam int DEF_REQUEST_BATCH = 8;

    // most requests one tick may raise
    localparam int MAX_REQUESTS = 8;

    // request opcodes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_REJECT = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;
    localparam logic [1:0] KIND_REQ    = 2'd3;

    // classified request handed from front to back
    typedef struct packed {
        logic        opcode;
        logic [30:0] start;
        logic [30:0] len;
        logic        bad;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] position;
        logic [30:0] length;
        logic        finished;
        logic        last;
    } res_t;

    // status of the back part seen by the front
    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

@@ rtl/core/wrt_front.sv @@
// Front part: takes requests, does the header checks that need no state and
// queues them for the back part. Depends on wrt_pkg.
module wrt_front
    import wrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [30:0] chunk_start,
    input  logic [30:0] chunk_length,
    input  logic [12:0] payload_length,
    input  logic        sender_matches,
    input  logic        header_ok,
    input  back_stat_t  stat,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t        slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        take;
    cmd_t        cls;

    // stateless classification
    always_comb
    begin
        cls.opcode = opcode;
        cls.start  = chunk_start;
        cls.len    = chunk_length;
        cls.bad    = !sender_matches || !header_ok || (chunk_length == 31'd0) ||
                     ({18'd0, payload_length} != chunk_length);
    end

    assign full      = (count_reg == 2'd2) || stat.clearing;
    assign take      = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    // two-entry request queue
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop && cmd_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(take) - 2'(cmd_pop && cmd_valid);
        end
    end

endmodule

@@ rtl/core/wrt_outq.sv @@
// Result queue between the back part and the result ports.
// Depends on wrt_pkg.
module wrt_outq
    import wrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_push,
    input  res_t in_res,
    output logic in_full,
    output logic empty,
    input  logic pop,
    output res_t head
);

    res_t        slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        take;
    logic        give;

    assign in_full = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign take    = in_push && !in_full;
    assign give    = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg[wr_ptr_reg] <= in_res;
        end
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (give)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(take) - 2'(give);
        end
    end

endmodule

@@ rtl/core/wrt_back.sv @@
// Back part: window checks, slot store, prefix advance, flush and request walk.
// Depends on wrt_pkg; holds the slot memory.
module wrt_back
    import wrt_pkg::*;
#(
    parameter int WINDOW_BYTES  = DEF_WINDOW_BYTES,
    parameter int CHUNK_BYTES   = DEF_CHUNK_BYTES,
    parameter int REQUEST_BATCH = DEF_REQUEST_BATCH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [30:0] file_length,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output back_stat_t  stat,
    output logic        out_push,
    output res_t        out_res,
    input  logic        out_full
);

    localparam int AW  = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
    localparam int PW  = $clog2(WINDOW_BYTES + 1);
    localparam int CW  = $clog2(WINDOW_BYTES + CHUNK_BYTES + 1);
    localparam int SW  = $clog2(CHUNK_BYTES + 1);
    localparam int LIM = (REQUEST_BATCH < MAX_REQUESTS) ? REQUEST_BATCH : MAX_REQUESTS;
    localparam int NW  = $clog2(LIM + 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHK1  = 4'd2;
    localparam logic [3:0] S_CHK2  = 4'd3;
    localparam logic [3:0] S_DRD   = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PCHK  = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_TINIT = 4'd9;
    localparam logic [3:0] S_TWALK = 4'd10;
    localparam logic [3:0] S_TCHK  = 4'd11;

    // slot memory: present flag over recorded length
    logic [PW:0]    mem [WINDOW_BYTES];
    logic [PW:0]    rd_reg;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [PW:0]    wr_data;

    logic [3:0]     state_reg, state_next;
    logic [3:0]     ret_reg, ret_next;
    cmd_t           cmd_reg, cmd_next;
    logic [30:0]    done_reg, done_next;
    logic [PW-1:0]  prefix_reg, prefix_next;
    logic [30:0]    off_reg, off_next;
    logic [30:0]    diff_reg, diff_next;
    logic           bad_reg, bad_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [CW-1:0]  cp_reg, cp_next;
    logic [32:0]    left_reg, left_next;
    logic [SW-1:0]  send_reg, send_next;
    logic [NW-1:0]  sent_reg, sent_next;
    logic           pend_valid_reg, pend_valid_next;
    res_t           pend_reg, pend_next;
    res_t           res_reg, res_next;

    logic           bad_w;
    logic           walk_go;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cmd_next        = cmd_reg;
        done_next       = done_reg;
        prefix_next     = prefix_reg;
        off_next        = off_reg;
        diff_next       = diff_reg;
        bad_next        = bad_reg;
        clr_next        = clr_reg;
        cp_next         = cp_reg;
        left_next       = left_reg;
        send_next       = send_reg;
        sent_next       = sent_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        cmd_pop         = 1'b0;
        out_push        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        bad_w           = bad_reg || (cmd_reg.len > diff_reg) ||
                          (off_reg >= 31'(WINDOW_BYTES)) ||
                          ({1'b0, cmd_reg.len} > (32'(WINDOW_BYTES) - {1'b0, off_reg}));
        walk_go         = (sent_reg < NW'(LIM)) && !left_reg[32] && (left_reg != 33'd0) &&
                          (cp_reg < CW'(WINDOW_BYTES));
        unique case (state_reg)
            S_CLR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(WINDOW_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    if (cmd.opcode == OP_TICK)
                    begin
                        left_next       = {2'b00, file_length} - {2'b00, done_reg};
                        cp_next         = CW'(prefix_reg);
                        sent_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_TINIT;
                    end
                    else
                    begin
                        state_next = S_CHK1;
                    end
                end
            end
            S_CHK1:
            begin
                bad_next   = cmd_reg.bad || (cmd_reg.start < done_reg) ||
                             (cmd_reg.start > file_length);
                diff_next  = file_length - cmd_reg.start;
                off_next   = cmd_reg.start - done_reg;
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                if (bad_w)
                begin
                    res_next   = '{KIND_REJECT, 31'd0, 31'd0, 1'b0, 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = off_reg[AW-1:0];
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                // duplicate offset check, then record the chunk
                if (rd_reg[PW])
                begin
                    res_next   = '{KIND_REJECT, 31'd0, 31'd0, 1'b0, 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = off_reg[AW-1:0];
                    wr_data    = {1'b1, cmd_reg.len[PW-1:0]};
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                if (prefix_reg < PW'(WINDOW_BYTES))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = prefix_reg[AW-1:0];
                    state_next = S_PCHK;
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end
            S_PCHK:
            begin
                if (rd_reg[PW] && (rd_reg[PW-1:0] != '0))
                begin
                    prefix_next = prefix_reg + rd_reg[PW-1:0];
                    state_next  = S_PRD;
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if ((({1'b0, done_reg} + 32'(prefix_reg)) >= {1'b0, file_length}) ||
                    (prefix_reg >= PW'(WINDOW_BYTES)))
                begin
                    done_next   = done_reg + 31'(prefix_reg);
                    res_next    = '{KIND_FLUSH, off_reg, 31'(prefix_reg), 1'b0, 1'b1};
                    prefix_next = '0;
                    clr_next    = '0;
                    ret_next    = S_CLR;
                end
                else
                begin
                    res_next = '{KIND_ACCEPT, off_reg, 31'd0, 1'b0, 1'b1};
                    ret_next = S_IDLE;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ret_reg;
                end
            end
            S_TINIT:
            begin
                left_next  = left_reg - 33'(prefix_reg);
                state_next = S_TWALK;
            end
            S_TWALK:
            begin
                if (walk_go)
                begin
                    send_next  = (left_reg < 33'(CHUNK_BYTES)) ? left_reg[SW-1:0]
                                                               : SW'(CHUNK_BYTES);
                    rd_en      = 1'b1;
                    rd_addr    = cp_reg[AW-1:0];
                    state_next = S_TCHK;
                end
                else if (pend_valid_reg)
                begin
                    res_next        = pend_reg;
                    res_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    ret_next        = S_IDLE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TCHK:
            begin
                // missing chunk: hold it back until we know whether it is the last
                cp_next    = cp_reg + CW'(send_reg);
                left_next  = left_reg - 33'(send_reg);
                state_next = S_TWALK;
                if (!rd_reg[PW])
                begin
                    sent_next       = sent_reg + NW'(1);
                    pend_next       = '{KIND_REQ, done_reg + 31'(cp_reg), 31'(send_reg),
                                        1'b0, 1'b0};
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_next   = pend_reg;
                        ret_next   = S_TWALK;
                        state_next = S_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result with the completion flag taken after the update
    always_comb
    begin
        out_res          = res_reg;
        out_res.finished = (done_reg >= file_length);
    end

    assign stat.clearing = (state_reg == S_CLR);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            ret_reg        <= S_IDLE;
            done_reg       <= '0;
            prefix_reg     <= '0;
            clr_reg        <= '0;
            sent_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            done_reg       <= done_next;
            prefix_reg     <= prefix_next;
            clr_reg        <= clr_next;
            sent_reg       <= sent_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        off_reg  <= off_next;
        diff_reg <= diff_next;
        bad_reg  <= bad_next;
        cp_reg   <= cp_next;
        left_reg <= left_next;
        send_reg <= send_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    // prefix never runs past the window
    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_reg <= PW'(WINDOW_BYTES))
        else $error("prefix beyond window");

    // a tick never raises more than the batch limit
    a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg <= NW'(LIM))
        else $error("request batch exceeded");

    // no request is taken while the store is being cleared
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !cmd_pop)
        else $error("request taken during clear");

    // a result is pushed only into a queue with room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into full queue");

    // a flush result leads into a clearing pass
    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && (res_reg.kind == KIND_FLUSH)) |=> (state_reg == S_CLR))
        else $error("flush without clear");

endmodule

@@ rtl/core/window_reassembly_tracker.sv @@
// Top level of the window reassembly tracker: configuration registers, front,
// back and result queue. Depends on wrt_pkg, wrt_front, wrt_back, wrt_outq.
//
//  channel   handshake                       payload
//  request   push / full                     opcode, chunk_start, chunk_length,
//                                            payload_length, sender_matches, header_ok
//  result    empty / pop                     result_kind, position, length,
//                                            finished, last
//  config    psel, penable, pwrite, pready   paddr, pwdata, prdata (file_length at 0)
//
// A data request runs the two check steps, the duplicate read and the record, then a
// prefix read and check per chunk the in-order prefix advances over, and a flush check;
// a rejected one ends at the window check or at the duplicate check. All are paced
// by the single read port of the slot memory. A flush adds a clearing pass over every
// slot; the same pass runs after reset, and full stays high while it runs.
// A tick walks the chunk positions with a read and check each, and emits each request.
// Up to two requests queue ahead of the back part and two results behind it.
module window_reassembly_tracker
    import wrt_pkg::*;
#(
    parameter int WINDOW_BYTES  = DEF_WINDOW_BYTES,
    parameter int CHUNK_BYTES   = DEF_CHUNK_BYTES,
    parameter int REQUEST_BATCH = DEF_REQUEST_BATCH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [30:0] chunk_start,
    input  logic [30:0] chunk_length,
    input  logic [12:0] payload_length,
    input  logic        sender_matches,
    input  logic        header_ok,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [30:0] position,
    output logic [30:0] length,
    output logic        finished,
    output logic        last
);

    logic [30:0] file_length_reg;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_pop;
    back_stat_t  stat;
    logic        res_push;
    res_t        res;
    logic        res_full;
    res_t        head;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {1'b0, file_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            file_length_reg <= pwdata[30:0];
        end
    end

    // request side
    wrt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .chunk_start    (chunk_start),
        .chunk_length   (chunk_length),
        .payload_length (payload_length),
        .sender_matches (sender_matches),
        .header_ok      (header_ok),
        .stat           (stat),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop)
    );

    // window logic
    wrt_back #(
        .WINDOW_BYTES  (WINDOW_BYTES),
        .CHUNK_BYTES   (CHUNK_BYTES),
        .REQUEST_BATCH (REQUEST_BATCH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_length (file_length_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .stat        (stat),
        .out_push    (res_push),
        .out_res     (res),
        .out_full    (res_full)
    );

    // result side
    wrt_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_push (res_push),
        .in_res  (res),
        .in_full (res_full),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign result_kind = head.kind;
    assign position    = head.position;
    assign length      = head.length;
    assign finished    = head.finished;
    assign last        = head.last;

endmodule
